@@ rtl/sfu_pkg.sv @@
// Shared constants, types and helpers for the SGD factor update block.
// Used by sfu_mac and sgd_factor_update; no dependencies.
package sfu_pkg;

  localparam int unsigned LatentLen  = 20;
  localparam int unsigned MovieRows  = 1024;
  localparam int unsigned UserRows   = 1024;
  localparam int unsigned MovieDepth = MovieRows * LatentLen;
  localparam int unsigned UserDepth  = UserRows * LatentLen;
  localparam int unsigned AddrW      = $clog2(MovieDepth > UserDepth ? MovieDepth : UserDepth);

  localparam int unsigned ActW    = 2;
  localparam int unsigned RowW    = 10;
  localparam int unsigned ElemW   = 5;
  localparam int unsigned ValW    = 16;
  localparam int unsigned RatingW = 8;
  localparam int unsigned ErrW    = 32;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CntW    = $clog2(LatentLen + 2);

  localparam int unsigned InTdataW  = 56;
  localparam int unsigned InTuserW  = 3;
  localparam int unsigned OutTdataW = 48;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;

  localparam int unsigned FracW    = 12;
  localparam int unsigned DotW     = 36;
  localparam int unsigned ErrCalcW = 26;
  localparam int unsigned MulAW    = 41;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned AccW     = 62;
  localparam int unsigned ShiftW   = 32;
  localparam int unsigned SumW     = AccW - ShiftW + 1;
  localparam int unsigned SlW      = 2 * CfgW + 1;

  localparam logic RegStep   = 1'b0;
  localparam logic RegLambda = 1'b1;

  typedef enum logic [ActW-1:0] {
    ActWrite = 2'd0,
    ActRead  = 2'd1,
    ActRate  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    AccHold  = 3'd0,
    AccClear = 3'd1,
    AccAdd   = 3'd2,
    AccLoad  = 3'd3,
    AccSub   = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    acc_op_e acc_op;
  } mac_ctrl_t;

  function automatic logic signed [ValW-1:0] sat16(input logic signed [SumW-1:0] v);
    logic same;
    same = (v[SumW-1:ValW-1] == '0) || (v[SumW-1:ValW-1] == '1);
    if (same) begin
      sat16 = v[ValW-1:0];
    end else if (v[SumW-1]) begin
      sat16 = {1'b1, {(ValW-1){1'b0}}};
    end else begin
      sat16 = {1'b0, {(ValW-1){1'b1}}};
    end
  endfunction

endpackage

@@ rtl/sfu_mac.sv @@
// Shared multiply-accumulate unit: one registered signed multiplier and a wide accumulator.
// Depends on sfu_pkg for widths and the control struct.
module sfu_mac import sfu_pkg::*; (
  input  logic                    clk_i,
  input  mac_ctrl_t               ctrl_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic signed [MulBW-1:0] b_i,
  output logic signed [ProdW-1:0] prod_o,
  output logic signed [AccW-1:0]  acc_o
);

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d, prod_ext;

  assign prod_ext = AccW'(prod_q);

  always_comb begin
    case (ctrl_i.acc_op)
      AccClear: acc_d = '0;
      AccAdd:   acc_d = acc_q + prod_ext;
      AccLoad:  acc_d = prod_ext <<< 4;
      AccSub:   acc_d = acc_q - prod_ext;
      default:  acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= ProdW'(a_i) * ProdW'(b_i);
    end
    acc_q <= acc_d;
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

@@ rtl/sgd_factor_update.sv @@
// Top level of the SGD matrix factorization update block: factor stores, sequencer, ports.
// Depends on sfu_pkg and sfu_mac.
//
// One input word is taken at a time; s_axis_tready is high only while the block is idle,
// and the finished result sits in an output register so the next word can be taken while
// it waits. A write action and an action that does nothing go from decode straight to the
// output register stage, and a read passes through a read wait state first. A rating is
// decoded, then forms the dot product (one element per cycle through the multiplier
// pipeline), forms the error and the two scale factors, and runs the update through states
// StU1 to StU6 for each element, which needs four products per element on the single 41x17
// multiplier and one read and one write port on each factor store, then loads the output
// register. The next word can be taken in the cycle after the result is loaded; a result
// still waiting in the output register holds the block until it is taken.
module sgd_factor_update import sfu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // movie_row, user_row, element_index, element_value, rating
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // action, side
  input  logic [InTuserW-1:0]  s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // prediction_error, read_value
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready
);

  typedef enum logic [14:0] {
    StIdle   = 15'b000000000000001,
    StDecode = 15'b000000000000010,
    StRdWait = 15'b000000000000100,
    StDot    = 15'b000000000001000,
    StErr    = 15'b000000000010000,
    StSe     = 15'b000000000100000,
    StSl     = 15'b000000001000000,
    StSlc    = 15'b000000010000000,
    StU1     = 15'b000000100000000,
    StU2     = 15'b000001000000000,
    StU3     = 15'b000010000000000,
    StU4     = 15'b000100000000000,
    StU5     = 15'b001000000000000,
    StU6     = 15'b010000000000000,
    StFin    = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  logic [ActW-1:0]        act_q;
  logic                   side_q;
  logic [RowW-1:0]        mrow_q, urow_q;
  logic [ElemW-1:0]       elem_q;
  logic signed [ValW-1:0] wval_q;
  logic [RatingW-1:0]     rating_q;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ElemW-1:0] idx_q, idx_d;

  logic [CfgW-1:0]         step_q, lambda_q;
  logic signed [ErrW-1:0]  err_q, res_err_q, out_err_q;
  logic signed [ValW-1:0]  res_rd_q, out_rd_q;
  logic signed [MulAW-1:0] se_q;
  logic signed [SlW-1:0]   sl_q;
  logic                    out_valid_q, out_valid_d;

  logic signed [ValW-1:0] mov_mem [MovieDepth];
  logic signed [ValW-1:0] usr_mem [UserDepth];
  logic signed [ValW-1:0] rd_m_q, rd_u_q;

  logic                   mem_re, mov_we, usr_we;
  logic [ElemW-1:0]       ridx, widx;
  logic [AddrW-1:0]       mbase, ubase, mov_raddr, usr_raddr, mov_waddr, usr_waddr;
  logic signed [ValW-1:0] wdata, upd_val;
  logic signed [SumW-1:0] upd_sum;

  mac_ctrl_t               mac_ctrl;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0]  acc;

  logic                        in_acc, fin_go, row_ok, elem_ok;
  logic signed [ErrCalcW-1:0]  err_calc;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == StIdle);
  assign fin_go        = (state_q == StFin) && (!out_valid_q || m_axis_tready);

  assign mbase     = AddrW'(mrow_q) * AddrW'(LatentLen);
  assign ubase     = AddrW'(urow_q) * AddrW'(LatentLen);
  assign mov_raddr = mbase + AddrW'(ridx);
  assign usr_raddr = ubase + AddrW'(ridx);
  assign mov_waddr = mbase + AddrW'(widx);
  assign usr_waddr = ubase + AddrW'(widx);

  assign row_ok  = side_q ? (32'(urow_q) < UserRows) : (32'(mrow_q) < MovieRows);
  assign elem_ok = 32'(elem_q) < LatentLen;

  assign err_calc = $signed({6'b0, rating_q, {FracW{1'b0}}})
                  - ErrCalcW'($signed(acc[DotW-1:FracW]));

  assign upd_sum = SumW'((state_q == StU4) ? rd_m_q : rd_u_q)
                 + SumW'($signed(acc[AccW-1:ShiftW]));
  assign upd_val = sat16(upd_sum);
  assign wdata   = (state_q == StDecode) ? wval_q : upd_val;

  always_comb begin
    state_d         = state_q;
    cnt_d           = cnt_q;
    idx_d           = idx_q;
    mem_re          = 1'b0;
    ridx            = '0;
    mov_we          = 1'b0;
    usr_we          = 1'b0;
    widx            = idx_q;
    mul_a           = '0;
    mul_b           = '0;
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = AccHold;
    unique case (state_q)
      StIdle: begin
        if (in_acc) state_d = StDecode;
      end
      StDecode: begin
        state_d = StFin;
        case (act_q)
          ActWrite: begin
            if (row_ok && elem_ok) begin
              widx   = elem_q;
              mov_we = !side_q;
              usr_we = side_q;
            end
          end
          ActRead: begin
            if (row_ok && elem_ok) begin
              mem_re  = 1'b1;
              ridx    = elem_q;
              state_d = StRdWait;
            end
          end
          ActRate: begin
            if (32'(mrow_q) < MovieRows && 32'(urow_q) < UserRows) begin
              mac_ctrl.acc_op = AccClear;
              cnt_d           = '0;
              state_d         = StDot;
            end
          end
          default: state_d = StFin;
        endcase
      end
      StRdWait: state_d = StFin;
      StDot: begin
        cnt_d = cnt_q + CntW'(1);
        if (32'(cnt_q) < LatentLen) begin
          mem_re = 1'b1;
          ridx   = ElemW'(cnt_q);
        end
        if (cnt_q != '0 && 32'(cnt_q) <= LatentLen) begin
          mac_ctrl.mul_en = 1'b1;
          mul_a           = MulAW'(rd_m_q);
          mul_b           = MulBW'(rd_u_q);
        end
        if (32'(cnt_q) >= 2) mac_ctrl.acc_op = AccAdd;
        if (32'(cnt_q) == LatentLen + 1) state_d = StErr;
      end
      StErr: state_d = StSe;
      StSe: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = MulAW'(err_q);
        mul_b           = MulBW'(step_q);
        state_d         = StSl;
      end
      StSl: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = MulAW'(lambda_q);
        mul_b           = MulBW'(step_q);
        state_d         = StSlc;
      end
      StSlc: begin
        mem_re  = 1'b1;
        ridx    = '0;
        idx_d   = '0;
        state_d = StU1;
      end
      StU1: begin
        mac_ctrl.mul_en = 1'b1;
        mul_a           = se_q;
        mul_b           = MulBW'(rd_u_q);
        state_d         = StU2;
      end
      StU2: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccLoad;
        mul_a           = MulAW'(sl_q);
        mul_b           = MulBW'(rd_m_q);
        state_d         = StU3;
      end
      StU3: begin
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccSub;
        mul_a           = se_q;
        mul_b           = MulBW'(rd_m_q);
        state_d         = StU4;
      end
      StU4: begin
        mov_we          = 1'b1;
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = AccLoad;
        mul_a           = MulAW'(sl_q);
        mul_b           = MulBW'(rd_u_q);
        state_d         = StU5;
      end
      StU5: begin
        mac_ctrl.acc_op = AccSub;
        state_d         = StU6;
      end
      StU6: begin
        usr_we = 1'b1;
        if (32'(idx_q) == LatentLen - 1) begin
          state_d = StFin;
        end else begin
          mem_re  = 1'b1;
          ridx    = idx_q + ElemW'(1);
          idx_d   = idx_q + ElemW'(1);
          state_d = StU1;
        end
      end
      StFin: begin
        if (fin_go) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    if (fin_go) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      step_q      <= CfgW'(66);
      lambda_q    <= CfgW'(66);
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegStep)   step_q   <= pwdata[CfgW-1:0];
        if (paddr[2] == RegLambda) lambda_q <= pwdata[CfgW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= s_axis_tuser[1:0];
      side_q   <= s_axis_tuser[2];
      mrow_q   <= s_axis_tdata[9:0];
      urow_q   <= s_axis_tdata[19:10];
      elem_q   <= s_axis_tdata[24:20];
      wval_q   <= s_axis_tdata[40:25];
      rating_q <= s_axis_tdata[48:41];
    end
    if (state_q == StDecode) begin
      res_err_q <= '0;
      res_rd_q  <= '0;
    end
    if (state_q == StRdWait) res_rd_q <= side_q ? rd_u_q : rd_m_q;
    if (state_q == StErr) begin
      err_q     <= ErrW'(err_calc);
      res_err_q <= ErrW'(err_calc);
    end
    if (state_q == StSl)  se_q <= prod[MulAW-1:0];
    if (state_q == StSlc) sl_q <= prod[SlW-1:0];
    if (fin_go) begin
      out_err_q <= res_err_q;
      out_rd_q  <= res_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mov_we) mov_mem[mov_waddr] <= wdata;
    if (mem_re) rd_m_q <= mov_mem[mov_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (usr_we) usr_mem[usr_waddr] <= wdata;
    if (mem_re) rd_u_q <= usr_mem[usr_raddr];
  end

  sfu_mac u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod),
    .acc_o  (acc)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_rd_q, out_err_q};
  assign pready        = 1'b1;
  assign prdata        = ApbDataW'((paddr[2] == RegLambda) ? lambda_q : step_q);

`ifndef NO_ASSERTIONS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> state_q == StDecode)
    else $error("accepted word did not reach decode");

  a_dot_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StErr |-> $past(state_q) == StDot && $past(cnt_q) == CntW'(LatentLen + 1))
    else $error("dot product left early");

  a_mov_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mov_we && mem_re |-> mov_waddr != mov_raddr)
    else $error("movie store read and write at one address");

  a_usr_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    usr_we && mem_re |-> usr_waddr != usr_raddr)
    else $error("user store read and write at one address");

  a_usr_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    usr_we |-> state_q == StU6 || state_q == StDecode)
    else $error("user store written outside its slots");
`endif

endmodule
